[sv/im2col_gather_unit_defines.svh]
// Assertion macros for the im2col gather unit.
// Used by the top level only; define NO_ASSERTIONS to compile them away.
`ifndef IM2COL_GATHER_UNIT_DEFINES_SVH
`define IM2COL_GATHER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Immediate implication, checked at every clock edge outside reset.
`define IM2C_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);
// Implication across the fixed request-to-result latency.
`define IM2C_ASSERT_DELAY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##RESULT_LATENCY (cons)) else $error(msg);
`else
`define IM2C_ASSERT_NOW(lbl, ante, cons, msg)
`define IM2C_ASSERT_DELAY(lbl, ante, cons, msg)
`endif
`endif

[sv/im2c_pkg.sv]
// Shared types, widths and codes of the im2col gather unit.
// No dependencies; imported by the top level, front end, queue and back end.
package im2c_pkg;

    localparam int STORE_DEPTH = 4096;
    localparam int MAX_DIM     = 256;
    localparam int MAX_KERNEL  = 16;

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    // Field widths
    localparam int LOAD_ADDR_W = 12;
    localparam int SAMPLE_W    = 32;
    localparam int CHAN_W      = 4;
    localparam int KERN_W      = 4;
    localparam int DST_W       = 8;

    // Register widths
    localparam int DIM_CFG_W  = 9;
    localparam int CCNT_W     = 5;
    localparam int SMALL_W    = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 9;

    // Datapath widths
    localparam int PROD_W      = DST_W + SMALL_W;
    localparam int SROW_W      = PROD_W + 1;
    localparam int SCOL_W      = DST_W + 2;
    localparam int PLANE_W     = 2 * DIM_CFG_W;
    localparam int CHAN_TERM_W = PLANE_W + CHAN_W;
    localparam int ROW_TERM_W  = 2 * DIM_CFG_W;
    localparam int SUM_W       = CHAN_TERM_W + 1;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    // Front holds up to two requests in flight
    localparam logic [QCNT_W-1:0] BUSY_LEVEL = QCNT_W'(QUEUE_DEPTH - 2);

    // Edges from an accepted read to its result
    localparam int RESULT_LATENCY = 4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP       = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT_COLS = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH     = 4'd7;

    typedef struct packed {
        logic                   cmd;
        logic [LOAD_ADDR_W-1:0] load_addr;
        logic [SAMPLE_W-1:0]    load_value;
        logic [CHAN_W-1:0]      chan_index;
        logic [KERN_W-1:0]      kern_row;
        logic [KERN_W-1:0]      kern_col;
        logic [DST_W-1:0]       dst_row;
        logic [DST_W-1:0]       dst_col;
    } t_in_item;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_out;
        logic                is_padding;
        logic                bad_request;
    } t_out_item;

    typedef struct packed {
        logic [DIM_CFG_W-1:0] image_height;
        logic [DIM_CFG_W-1:0] image_width;
        logic [CCNT_W-1:0]    channel_count;
        logic [SMALL_W-1:0]   pad_top;
        logic [SMALL_W-1:0]   pad_left_cols;
        logic [SMALL_W-1:0]   row_stride;
        logic [DIM_CFG_W-1:0] out_height;
        logic [DIM_CFG_W-1:0] out_width;
    } t_cfg;

    typedef struct packed {
        logic                   is_read;
        logic [LOAD_ADDR_W-1:0] load_addr;
        logic [SAMPLE_W-1:0]    load_value;
        logic                   bad;
        logic                   pad;
        logic [CHAN_TERM_W-1:0] chan_term;
        logic [ROW_TERM_W-1:0]  row_term;
        logic [DIM_CFG_W-1:0]   col;
    } t_q_entry;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_q_status;

endpackage

[sv/im2col_gather_unit.sv]
// Top level of the im2col gather unit: configuration registers, front end,
// request queue and back end. Depends on im2c_pkg and all im2c_* modules.
//
//   channel   ports                               handshake
//   -------   ---------------------------------   --------------------------------
//   request   start, busy, i_item                 taken when start & !busy
//   result    o_result_strobe, o_result           one cycle, no back-pressure
//   config    i_cfg_we, i_cfg_idx, i_cfg_data     written when i_cfg_we
//
// One request per cycle, sustained, while busy is low. A read's result passes
// through two front stages, the queue, then the store read in the back end.
// Loads write the store and give no result.
// Reset (synchronous, active low) empties the pipeline and the queue and
// restores the registers; the image store keeps its contents.
// The back end drains the queue each cycle, so busy only rises if the queue
// ever fills to within the two requests the front can hold.
`include "im2col_gather_unit_defines.svh"
module im2col_gather_unit import im2c_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  t_in_item              i_item,
    output logic                  o_result_strobe,
    output t_out_item             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      accept;
    logic      q_push;
    t_q_entry  q_in;
    logic      q_pop;
    t_q_entry  q_head;
    t_q_status q_status;

    // Configuration registers; writes beyond the list drop silently
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_height  <= DIM_CFG_W'(1);
            r_cfg.image_width   <= DIM_CFG_W'(1);
            r_cfg.channel_count <= CCNT_W'(1);
            r_cfg.pad_top       <= '0;
            r_cfg.pad_left_cols <= '0;
            r_cfg.row_stride    <= SMALL_W'(1);
            r_cfg.out_height    <= DIM_CFG_W'(1);
            r_cfg.out_width     <= DIM_CFG_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_HEIGHT: begin
                    r_cfg.image_height <= i_cfg_data[DIM_CFG_W-1:0];
                end
                CFG_IMAGE_WIDTH: begin
                    r_cfg.image_width <= i_cfg_data[DIM_CFG_W-1:0];
                end
                CFG_CHANNEL_COUNT: begin
                    r_cfg.channel_count <= i_cfg_data[CCNT_W-1:0];
                end
                CFG_PAD_TOP: begin
                    r_cfg.pad_top <= i_cfg_data[SMALL_W-1:0];
                end
                CFG_PAD_LEFT_COLS: begin
                    r_cfg.pad_left_cols <= i_cfg_data[SMALL_W-1:0];
                end
                CFG_ROW_STRIDE: begin
                    r_cfg.row_stride <= i_cfg_data[SMALL_W-1:0];
                end
                CFG_OUT_HEIGHT: begin
                    r_cfg.out_height <= i_cfg_data[DIM_CFG_W-1:0];
                end
                CFG_OUT_WIDTH: begin
                    r_cfg.out_width <= i_cfg_data[DIM_CFG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Hold off new requests while the queue cannot absorb those in flight
    assign busy   = (q_status.count >= BUSY_LEVEL);
    assign accept = start && !busy;

    im2c_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    im2c_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_entry  (q_in),
        .i_pop    (q_pop),
        .o_head   (q_head),
        .o_status (q_status)
    );

    im2c_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!q_status.empty),
        .i_entry  (q_head),
        .o_pop    (q_pop),
        .o_strobe (o_result_strobe),
        .o_result (o_result)
    );

    // Every accepted read yields a result after the fixed latency
    `IM2C_ASSERT_DELAY(a_read_gives_result, accept && (i_item.cmd == CMD_READ), o_result_strobe, "read request produced no result")
    // A load never yields a result
    `IM2C_ASSERT_DELAY(a_load_silent, accept && (i_item.cmd == CMD_LOAD), !o_result_strobe, "load request produced a result")
    // Busy must keep the queue from overflowing
    `IM2C_ASSERT_NOW(a_queue_no_overflow, q_push, !q_status.full, "push into full queue")
    // Flagged results carry zero data and at most one flag
    `IM2C_ASSERT_NOW(a_flag_zero, o_result_strobe && (o_result.is_padding || o_result.bad_request), (o_result.sample_out == '0) && !(o_result.is_padding && o_result.bad_request), "flagged result carries data")

endmodule

[sv/im2c_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module im2c_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/im2c_front.sv]
// Front end: classifies requests and computes source position and address terms.
// Depends on im2c_pkg.
module im2c_front import im2c_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output logic     o_push,
    output t_q_entry o_entry
);

    // Stage 1
    logic                   r_f1_valid;
    logic                   r_f1_read;
    logic [LOAD_ADDR_W-1:0] r_f1_addr;
    logic [SAMPLE_W-1:0]    r_f1_value;
    logic [CHAN_W-1:0]      r_f1_chan;
    logic                   r_f1_bad;
    logic [SROW_W-1:0]      r_f1_srow;
    logic [SCOL_W-1:0]      r_f1_scol;
    logic [PLANE_W-1:0]     r_plane;

    // Stage 2
    logic     r_f2_valid;
    t_q_entry r_f2;

    logic [PROD_W-1:0] n_prod;
    logic [SROW_W-1:0] n_srow;
    logic [SCOL_W-1:0] n_scol;
    logic              n_bad;
    logic              n_pad;

    always_comb begin
        n_bad = ({1'b0, i_item.chan_index} >= CCNT_W'(i_cfg.channel_count))
              || ({1'b0, i_item.dst_row} >= i_cfg.out_height)
              || ({1'b0, i_item.dst_col} >= i_cfg.out_width)
              || (32'(i_item.dst_row) >= MAX_DIM)
              || (32'(i_item.dst_col) >= MAX_DIM)
              || (32'(i_item.kern_row) >= MAX_KERNEL)
              || (32'(i_item.kern_col) >= MAX_KERNEL);
        n_prod = PROD_W'(i_item.dst_row) * PROD_W'(i_cfg.row_stride);
        n_srow = SROW_W'(n_prod) - SROW_W'(i_cfg.pad_top) + SROW_W'(i_item.kern_row);
        n_scol = SCOL_W'(i_item.dst_col) - SCOL_W'(i_cfg.pad_left_cols)
               + SCOL_W'(i_item.kern_col);
    end

    // Negative positions show as a set sign bit
    always_comb begin
        n_pad = r_f1_srow[SROW_W-1]
             || (r_f1_srow[SROW_W-2:0] >= (SROW_W-1)'(i_cfg.image_height))
             || r_f1_scol[SCOL_W-1]
             || (r_f1_scol[SCOL_W-2:0] >= (SCOL_W-1)'(i_cfg.image_width));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_f2_valid <= 1'b0;
        end else begin
            r_f1_valid <= i_accept;
            r_f2_valid <= r_f1_valid;
        end
        r_plane    <= PLANE_W'(i_cfg.image_height) * PLANE_W'(i_cfg.image_width);
        r_f1_read  <= (i_item.cmd == CMD_READ);
        r_f1_addr  <= i_item.load_addr;
        r_f1_value <= i_item.load_value;
        r_f1_chan  <= i_item.chan_index;
        r_f1_bad   <= n_bad;
        r_f1_srow  <= n_srow;
        r_f1_scol  <= n_scol;

        r_f2.is_read    <= r_f1_read;
        r_f2.load_addr  <= r_f1_addr;
        r_f2.load_value <= r_f1_value;
        r_f2.bad        <= r_f1_bad;
        r_f2.pad        <= n_pad;
        r_f2.chan_term  <= CHAN_TERM_W'(r_f1_chan) * CHAN_TERM_W'(r_plane);
        r_f2.row_term   <= ROW_TERM_W'(r_f1_srow[DIM_CFG_W-1:0])
                         * ROW_TERM_W'(i_cfg.image_width);
        r_f2.col        <= r_f1_scol[DIM_CFG_W-1:0];
    end

    assign o_push  = r_f2_valid;
    assign o_entry = r_f2;

endmodule

[sv/im2c_queue.sv]
// Short request queue between front and back end.
// Depends on im2c_pkg.
module im2c_queue import im2c_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_q_entry  i_entry,
    input  logic      i_pop,
    output t_q_entry  o_head,
    output t_q_status o_status
);

    t_q_entry          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && (r_count != QCNT_W'(QUEUE_DEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.count = r_count;

endmodule

[sv/im2c_back.sv]
// Back end: final address sum, image store access and result register.
// Depends on im2c_pkg and im2c_ram.
module im2c_back import im2c_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_q_entry  i_entry,
    output logic      o_pop,
    output logic      o_strobe,
    output t_out_item o_result
);

    logic [SUM_W-1:0]    sum;
    logic [SUM_W-1:0]    load_wide;
    logic                in_range;
    logic                we;
    logic [SAMPLE_W-1:0] rdata;

    logic r_strobe;
    logic r_use_mem;
    logic r_pad;
    logic r_bad;

    // Drain one entry every cycle; the receiver never stalls
    assign o_pop = i_valid;

    always_comb begin
        sum = SUM_W'(i_entry.chan_term) + SUM_W'(i_entry.row_term) + SUM_W'(i_entry.col);
        in_range  = (sum < SUM_W'(STORE_DEPTH));
        load_wide = SUM_W'(i_entry.load_addr);
        we = i_valid && !i_entry.is_read && (load_wide < SUM_W'(STORE_DEPTH));
    end

    im2c_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (load_wide[ADDR_W-1:0]),
        .i_wdata (i_entry.load_value),
        .i_raddr (sum[ADDR_W-1:0]),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_valid && i_entry.is_read;
        end
        r_bad     <= i_entry.bad;
        r_pad     <= !i_entry.bad && i_entry.pad;
        r_use_mem <= !i_entry.bad && !i_entry.pad && in_range;
    end

    assign o_strobe             = r_strobe;
    assign o_result.sample_out  = r_use_mem ? rdata : '0;
    assign o_result.is_padding  = r_pad;
    assign o_result.bad_request = r_bad;

endmodule
